[hdl/multi_reader_ring_buffer_defines.svh]
// assertion macros shared by the checker of the ring buffer
// no dependencies
`ifndef MULTI_READER_RING_BUFFER_DEFINES_SVH
`define MULTI_READER_RING_BUFFER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MRRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MRRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/mrrb_pkg.sv]
// package of the multi-reader ring buffer: sizes, op and status codes
// no dependencies
`default_nettype none
package mrrb_pkg;
  localparam int unsigned Depth = 4096;
  localparam int unsigned Procs = 32;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SlotW = $clog2(Procs);
  localparam int unsigned SlotCntW = $clog2(Procs + 1);

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_FORK   = 3'd4;
  localparam logic [2:0] OP_CLOSE  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_WRONG  = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;
  localparam logic [1:0] ST_ERR    = 2'd3;

  // per-slot record held in the slot table
  typedef struct packed {
    logic            used;
    logic [15:0]     pid;
    logic            ropen;
    logic            wopen;
    logic [PtrW-1:0] pos;
    logic [CntW-1:0] cons;
  } slot_t;

  // one pass of the slot scanner
  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] ppid;
    logic [CntW-1:0] fill;
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_idx;
    logic             phit;
    logic [SlotW-1:0] pidx;
    logic             free;
    logic [SlotW-1:0] free_idx;
    logic             any_rd;
    logic [CntW-1:0]  least;
    logic             any_used;
  } scan_res_t;
endpackage
`default_nettype wire

[hdl/multi_reader_ring_buffer.sv]
// top level of the multi-reader byte ring buffer: sequencer, slot table, store
// depends on mrrb_pkg and mrrb_scan
//
//  channel | valid    | stall    | payload
//  in      | valid_i  | stall_o  | op_i requester_pid_i parent_pid_i port_end_i data_in_i
//          |          |          | last_of_call_i
//  out     | valid_o  | stall_i  | status_o data_out_o amount_o last_o
//
// a request runs one scanner pass over the slot table, one slot entry a cycle
// a read that moves a byte adds a store read state; flush and create add a sweep over every slot
// a close that finds its slot adds a second scanner pass
// reset clears control state; the byte store has no reset
// a stalled result holds in the output register; the next one waits in staging
`default_nettype none
module multi_reader_ring_buffer import mrrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [15:0] requester_pid_i,
  input  wire logic [15:0] parent_pid_i,
  input  wire logic        port_end_i,
  input  wire logic [7:0]  data_in_i,
  input  wire logic        last_of_call_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       data_out_o,
  output logic [CntW-1:0]  amount_o,
  output logic             last_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RDMEM = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;

  // latched request
  logic [2:0]  op_q;
  logic [15:0] pid_q;
  logic        end_q;
  logic [7:0]  din_q;
  logic        last_q;

  // global counters
  logic [CntW-1:0] fill_q;
  logic [PtrW-1:0] oldest_q;
  logic [PtrW-1:0] widx_q;

  // slot table and byte store
  slot_t     slots_q [Procs];
  logic [7:0] store_q [Depth];
  logic [7:0] rdata_q;

  // sweep counter for flush and clear passes
  logic [SlotW-1:0] swp_q;
  logic [CntW-1:0]  least_q;
  logic             post_create_q;

  // staging register for a result computed while the output waits
  logic [1:0]      pst_q;
  logic [7:0]      pdata_q;
  logic [CntW-1:0] pamt_q;
  logic            plast_q;

  // result register
  logic            ovalid_q;
  logic [1:0]      ost_q;
  logic [7:0]      odata_q;
  logic [CntW-1:0] oamt_q;
  logic            olast_q;

  // scanner hookup
  logic             scan_start;
  logic [SlotW-1:0] scan_idx;
  logic             scan_done;
  scan_res_t        sres;
  scan_req_t        sreq;
  logic             post_start_q;

  // the scanner latches the request at the accepting edge
  assign sreq.pid  = requester_pid_i;
  assign sreq.ppid = parent_pid_i;
  assign sreq.fill = fill_q;

  mrrb_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .req_i   (sreq),
    .ent_i   (slots_q[scan_idx]),
    .idx_o   (scan_idx),
    .done_o  (scan_done),
    .res_o   (sres)
  );

  assign stall_o    = (state_q != S_IDLE);
  assign valid_o    = ovalid_q;
  assign status_o   = ost_q;
  assign data_out_o = odata_q;
  assign amount_o   = oamt_q;
  assign last_o     = olast_q;

  logic in_acc;
  assign in_acc = valid_i && !stall_o;
  assign scan_start = in_acc || post_start_q;

  slot_t hs;
  assign hs = slots_q[sres.hit_idx];

  // sequencer state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SCAN;
      S_SCAN:  if (scan_done) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_OUT;
        if (op_q == OP_CREATE) state_d = S_CLEAR;
        else if (op_q == OP_FLUSH) state_d = S_FLUSH;
        else if (op_q == OP_READ && !end_q && sres.hit && hs.ropen &&
                 hs.cons < fill_q) state_d = S_RDMEM;
        else if (op_q == OP_CLOSE && sres.hit) state_d = S_POST;
      end
      S_RDMEM: state_d = S_OUT;
      S_FLUSH: if (swp_q == SlotW'(Procs - 1)) state_d = S_OUT;
      S_CLEAR: if (swp_q == SlotW'(Procs - 1)) state_d = S_OUT;
      S_POST:  if (scan_done) state_d = S_OUT;
      S_OUT:   if (!ovalid_q || !stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      widx_q   <= '0;
      swp_q    <= '0;
      ovalid_q <= 1'b0;
      post_create_q <= 1'b0;
      for (int i = 0; i < Procs; i++) slots_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!ovalid_q || !stall_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && !stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_EXEC: begin
          swp_q <= '0;
          case (op_q)
            OP_CREATE: begin
              fill_q <= '0; oldest_q <= '0; widx_q <= '0;
              post_create_q <= 1'b1;
            end
            OP_WRITE: begin
              if (end_q && sres.hit && hs.wopen && fill_q < CntW'(Depth)) begin
                widx_q <= widx_q + 1'b1;
                fill_q <= fill_q + 1'b1;
              end
            end
            OP_READ: begin
              if (!end_q && sres.hit && hs.ropen && hs.cons < fill_q) begin
                slots_q[sres.hit_idx].pos  <= hs.pos + 1'b1;
                slots_q[sres.hit_idx].cons <= hs.cons + 1'b1;
              end
            end
            OP_FLUSH: begin
              if (sres.any_rd) begin
                oldest_q <= oldest_q + PtrW'(sres.least);
                fill_q   <= fill_q - sres.least;
              end
            end
            OP_FORK: begin
              if ((sres.hit || sres.free) && sres.phit) begin
                slots_q[sres.hit ? sres.hit_idx : sres.free_idx] <= '{
                  used: 1'b1, pid: pid_q,
                  ropen: slots_q[sres.pidx].ropen,
                  wopen: slots_q[sres.pidx].wopen,
                  pos: slots_q[sres.pidx].pos,
                  cons: slots_q[sres.pidx].cons};
              end
            end
            OP_CLOSE: begin
              if (sres.hit) begin
                if (!end_q) slots_q[sres.hit_idx].ropen <= 1'b0;
                else        slots_q[sres.hit_idx].wopen <= 1'b0;
                if ((!end_q || !hs.ropen) && (end_q || !hs.wopen))
                  slots_q[sres.hit_idx].used <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_FLUSH: begin
          if (slots_q[swp_q].used && slots_q[swp_q].ropen)
            slots_q[swp_q].cons <= slots_q[swp_q].cons - least_q;
          swp_q <= swp_q + 1'b1;
        end
        S_CLEAR: begin
          if (post_create_q && swp_q == '0)
            slots_q[0] <= '{used: 1'b1, pid: pid_q, ropen: 1'b1, wopen: 1'b1,
                            pos: '0, cons: '0};
          else
            slots_q[swp_q] <= '0;
          swp_q <= swp_q + 1'b1;
          if (swp_q == SlotW'(Procs - 1)) post_create_q <= 1'b0;
        end
        S_POST: begin
          if (scan_done && !sres.any_used) begin
            fill_q <= '0; oldest_q <= '0; widx_q <= '0;
            for (int i = 0; i < Procs; i++) slots_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // second scanner pass after close shares the same unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) post_start_q <= 1'b0;
    else post_start_q <= (state_q == S_EXEC) && (state_d == S_POST);
  end

  // payload registers and byte store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_i; pid_q <= requester_pid_i;
      end_q <= port_end_i; din_q <= data_in_i; last_q <= last_of_call_i;
    end
    if (state_q == S_EXEC && op_q == OP_WRITE && end_q && sres.hit && hs.wopen &&
        fill_q < CntW'(Depth))
      store_q[widx_q] <= din_q;
    rdata_q <= store_q[hs.pos];
    if (state_q == S_EXEC) least_q <= sres.any_rd ? sres.least : '0;
    if (state_q == S_EXEC) begin
      plast_q <= last_q;
      pdata_q <= '0;
      pamt_q  <= '0;
      pst_q   <= ST_OK;
      case (op_q)
        OP_CREATE: ;
        OP_WRITE: begin
          if (!end_q) pst_q <= ST_WRONG;
          else if (!sres.hit) pst_q <= ST_ERR;
          else if (!hs.wopen) pst_q <= ST_CLOSED;
          else if (fill_q < CntW'(Depth)) pamt_q <= CntW'(1);
        end
        OP_READ: begin
          if (end_q) pst_q <= ST_WRONG;
          else if (!sres.hit) pst_q <= ST_ERR;
          else if (!hs.ropen) pst_q <= ST_CLOSED;
          else if (hs.cons < fill_q) pamt_q <= CntW'(1);
        end
        OP_FLUSH: pamt_q <= sres.any_rd ? sres.least : '0;
        OP_FORK: if (!((sres.hit || sres.free) && sres.phit)) pst_q <= ST_ERR;
        OP_CLOSE: if (!sres.hit) pst_q <= ST_ERR;
        default: pst_q <= ST_ERR;
      endcase
    end
    if (state_q == S_RDMEM) pdata_q <= rdata_q;
    // move the staged result out once the output register is free
    if (state_q == S_OUT && (!ovalid_q || !stall_i)) begin
      ost_q   <= pst_q;
      odata_q <= pdata_q;
      oamt_q  <= pamt_q;
      olast_q <= plast_q;
    end
  end
endmodule
`default_nettype wire

[hdl/mrrb_scan.sv]
// slot scanner: walks the slot table one entry per cycle with one compare unit
// depends on mrrb_pkg
`default_nettype none
module mrrb_scan import mrrb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire scan_req_t req_i,
  input  wire slot_t     ent_i,
  output logic [SlotW-1:0] idx_o,
  output logic           done_o,
  output scan_res_t      res_o
);
  logic             busy_q, busy_d;
  logic [SlotW-1:0] idx_q, idx_d;
  scan_res_t        res_q, res_d;
  scan_req_t        req_q, req_d;
  logic             done_q, done_d;

  assign idx_o  = idx_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // one entry compared per cycle
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    res_d  = res_q;
    req_d  = req_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      req_d  = req_i;
      res_d  = '0;
      res_d.least = req_i.fill;
    end else if (busy_q) begin
      if (ent_i.used && ent_i.pid == req_q.pid && !res_q.hit) begin
        res_d.hit = 1'b1;
        res_d.hit_idx = idx_q;
      end
      if (ent_i.used && ent_i.pid == req_q.ppid && !res_q.phit) begin
        res_d.phit = 1'b1;
        res_d.pidx = idx_q;
      end
      if (!ent_i.used && !res_q.free) begin
        res_d.free = 1'b1;
        res_d.free_idx = idx_q;
      end
      if (ent_i.used) res_d.any_used = 1'b1;
      if (ent_i.used && ent_i.ropen) begin
        res_d.any_rd = 1'b1;
        if (ent_i.cons < res_q.least) res_d.least = ent_i.cons;
      end
      if (idx_q == SlotW'(Procs - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      done_q <= 1'b0;
      res_q  <= '0;
      req_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      done_q <= done_d;
      res_q  <= res_d;
      req_q  <= req_d;
    end
  end
endmodule
`default_nettype wire

[hdl/mrrb_checker.sv]
// port-level checker of the ring buffer, bound to the top level
// depends on mrrb_pkg and the defines header
`default_nettype none
`include "multi_reader_ring_buffer_defines.svh"
module mrrb_checker import mrrb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic valid_i,
  input wire logic stall_o,
  input wire logic valid_o,
  input wire logic stall_i,
  input wire logic [1:0] status_o,
  input wire logic [7:0] data_out_o,
  input wire logic [CntW-1:0] amount_o
);
  // a stalled result holds
  `MRRB_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(data_out_o))
  // an accepted request makes the block busy
  `MRRB_ASSERT_NXT(a_busy, clk_i, rst_ni, valid_i && !stall_o, stall_o)
  // errors move no bytes
  `MRRB_ASSERT_IMP(a_err, clk_i, rst_ni, valid_o && status_o != ST_OK, amount_o == '0)
  // amount never exceeds the depth
  `MRRB_ASSERT_IMP(a_amt, clk_i, rst_ni, valid_o, amount_o <= CntW'(Depth))
endmodule
bind multi_reader_ring_buffer mrrb_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .status_o(status_o),
  .data_out_o(data_out_o), .amount_o(amount_o)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench of the multi-reader byte ring buffer
// depends on mrrb_pkg and multi_reader_ring_buffer; drives requests and checks every result beat
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrb_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] pid;
    logic [15:0] ppid;
    logic        pe;
    logic [7:0]  din;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [1:0]      st;
    logic [7:0]      dout;
    logic [CntW-1:0] amt;
    logic            last;
  } res_t;

  // directed row: request, whether the result is typed in, typed result
  typedef struct packed {
    req_t      rq;
    logic      typed;
    logic [1:0] st;
    logic [7:0] dout;
    logic [CntW-1:0] amt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [2:0] op_i = OP_FLUSH;
  logic [15:0] requester_pid_i = '0;
  logic [15:0] parent_pid_i = '0;
  logic port_end_i = 1'b0;
  logic [7:0] data_in_i = '0;
  logic last_of_call_i = 1'b0;
  logic stall_o, valid_o, last_o;
  logic [1:0] status_o;
  logic [7:0] data_out_o;
  logic [CntW-1:0] amount_o;

  always #5 clk = ~clk;

  multi_reader_ring_buffer uut (
    .clk_i(clk), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .op_i(op_i), .requester_pid_i(requester_pid_i), .parent_pid_i(parent_pid_i),
    .port_end_i(port_end_i), .data_in_i(data_in_i), .last_of_call_i(last_of_call_i),
    .valid_o(valid_o), .stall_i(stall_i), .status_o(status_o),
    .data_out_o(data_out_o), .amount_o(amount_o), .last_o(last_o)
  );

  // shadow copy of the buffer state
  logic [7:0] byte_mem [Depth];
  int unsigned fill, oldest, wr_idx;
  bit s_used [Procs];
  logic [15:0] s_pid [Procs];
  bit s_ro [Procs];
  bit s_wo [Procs];
  int unsigned s_pos [Procs];
  int unsigned s_cons [Procs];

  res_t pending_q [$];
  int unsigned errors = 0;
  int unsigned n_req = 0, n_res = 0, n_full = 0, n_err = 0;
  int unsigned tx_idle = 0, rx_idle = 0;
  bit hold_rx = 1'b0, hold_go = 1'b0;
  bit cur_typed = 1'b0;
  res_t cur_exp;
  logic [15:0] pid_pool [8];

  function automatic void wipe_state();
    fill = 0; oldest = 0; wr_idx = 0;
    for (int i = 0; i < Procs; i++) begin
      s_used[i] = 0; s_pid[i] = '0; s_ro[i] = 0; s_wo[i] = 0;
      s_pos[i] = 0; s_cons[i] = 0;
    end
  endfunction

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < Procs; i++)
      if (s_used[i] && s_pid[i] == id) return i;
    return Procs;
  endfunction

  // apply one request to the shadow state and return its result
  function automatic res_t apply_request(req_t r);
    res_t o;
    int s, c, p;
    int unsigned least;
    bit any;
    o = '{st: ST_OK, dout: 8'h00, amt: '0, last: r.last};
    case (r.op)
      OP_CREATE: begin
        wipe_state();
        s_used[0] = 1; s_pid[0] = r.pid; s_ro[0] = 1; s_wo[0] = 1;
      end
      OP_WRITE: begin
        s = find_slot(r.pid);
        if (r.pe != 1'b1) o.st = ST_WRONG;
        else if (s >= Procs) o.st = ST_ERR;
        else if (!s_wo[s]) o.st = ST_CLOSED;
        else if (fill < Depth) begin
          byte_mem[wr_idx] = r.din;
          wr_idx = (wr_idx + 1) % Depth;
          fill++;
          o.amt = 1;
        end else n_full++;
      end
      OP_READ: begin
        s = find_slot(r.pid);
        if (r.pe != 1'b0) o.st = ST_WRONG;
        else if (s >= Procs) o.st = ST_ERR;
        else if (!s_ro[s]) o.st = ST_CLOSED;
        else if (s_cons[s] < fill) begin
          o.dout = byte_mem[s_pos[s]];
          s_pos[s] = (s_pos[s] + 1) % Depth;
          s_cons[s]++;
          o.amt = 1;
        end
      end
      OP_FLUSH: begin
        least = fill; any = 0;
        for (int i = 0; i < Procs; i++)
          if (s_used[i] && s_ro[i]) begin
            any = 1;
            if (s_cons[i] < least) least = s_cons[i];
          end
        if (!any) least = 0;
        oldest = (oldest + least) % Depth;
        fill -= least;
        for (int i = 0; i < Procs; i++)
          if (s_used[i] && s_ro[i]) s_cons[i] -= least;
        o.amt = least;
      end
      OP_FORK: begin
        c = find_slot(r.pid);
        if (c >= Procs)
          for (c = 0; c < Procs; c++) if (!s_used[c]) break;
        p = find_slot(r.ppid);
        if (c >= Procs || p >= Procs) o.st = ST_ERR;
        else begin
          s_used[c] = 1; s_pid[c] = r.pid;
          s_ro[c] = s_ro[p]; s_wo[c] = s_wo[p];
          s_pos[c] = s_pos[p]; s_cons[c] = s_cons[p];
        end
      end
      OP_CLOSE: begin
        s = find_slot(r.pid);
        if (s >= Procs) o.st = ST_ERR;
        else begin
          if (r.pe == 1'b0) s_ro[s] = 0; else s_wo[s] = 0;
          if (!s_ro[s] && !s_wo[s]) s_used[s] = 0;
          any = 0;
          for (int i = 0; i < Procs; i++) if (s_used[i]) any = 1;
          if (!any) wipe_state();
        end
      end
      default: o.st = ST_ERR;
    endcase
    return o;
  endfunction

  // accept requests and check result beats at the rising edge
  always @(posedge clk) begin
    res_t got, want;
    if (rst_ni && valid_i && !stall_o) begin
      want = apply_request('{op: op_i, pid: requester_pid_i, ppid: parent_pid_i,
                             pe: port_end_i, din: data_in_i, last: last_of_call_i});
      if (cur_typed) want = cur_exp;
      pending_q.push_back(want);
      n_req++;
    end
    if (rst_ni && valid_o && !stall_i) begin
      got = '{st: status_o, dout: data_out_o, amt: amount_o, last: last_o};
      n_res++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.st != want.st) begin
          $error("status expected %0d actual %0d", want.st, got.st); errors++;
        end
        if (got.dout != want.dout) begin
          $error("data_out expected %0h actual %0h", want.dout, got.dout); errors++;
        end
        if (got.amt != want.amt) begin
          $error("amount expected %0d actual %0d", want.amt, got.amt); errors++;
        end
        if (got.last != want.last) begin
          $error("last expected %0d actual %0d", want.last, got.last); errors++;
        end
        if (got.st != ST_OK) n_err++;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    stall_i <= hold_rx || ($urandom_range(99) < rx_idle);
  end

  initial begin
    wait (hold_go);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  // offer one request beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(req_t r, bit typed, res_t ex);
    while ($urandom_range(99) < tx_idle) begin
      valid_i <= 1'b0;
      @(negedge clk);
    end
    valid_i <= 1'b1;
    op_i <= r.op; requester_pid_i <= r.pid; parent_pid_i <= r.ppid;
    port_end_i <= r.pe; data_in_i <= r.din; last_of_call_i <= r.last;
    cur_typed <= typed; cur_exp <= ex;
    do @(posedge clk); while (stall_o);
    @(negedge clk);
  endtask

  task automatic send_req(req_t r);
    send_beat(r, 1'b0, '0);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (3 * Procs + 20) @(negedge clk);
  endtask

  function automatic req_t mk(logic [2:0] op, logic [15:0] pid, logic [15:0] ppid,
                              logic pe, logic [7:0] din);
    return '{op: op, pid: pid, ppid: ppid, pe: pe, din: din, last: 1'($urandom)};
  endfunction

  // random request, mostly well formed against the current client ids
  function automatic req_t rand_req();
    req_t r;
    int k;
    k = $urandom_range(99);
    r = mk(OP_FLUSH, pid_pool[$urandom_range(7)], pid_pool[$urandom_range(7)],
           1'b0, 8'($urandom));
    if (k < 32) begin r.op = OP_WRITE; r.pe = 1'b1; end
    else if (k < 62) r.op = OP_READ;
    else if (k < 70) r.op = OP_FLUSH;
    else if (k < 80) r.op = OP_FORK;
    else if (k < 88) begin r.op = OP_CLOSE; r.pe = 1'($urandom); end
    else if (k < 90) r.op = OP_CREATE;
    else if (k < 93) r.op = 3'($urandom_range(6, 7));
    else if (k < 96) begin r.op = 3'($urandom_range(1, 2)); r.pe = ~r.pe; end
    else begin
      r.op = 3'($urandom_range(1, 5)); r.pid = 16'($urandom); r.pe = 1'($urandom);
    end
    return r;
  endfunction

  localparam int NDir = 23;
  dir_row_t dir_tab [NDir] = '{
    '{'{OP_WRITE, 16'h0005, 16'h0000, 1'b1, 8'h00, 1'b0}, 1'b1, ST_ERR, 8'h00, 13'd0},
    '{'{OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1}, 1'b1, ST_ERR, 8'h00, 13'd0},
    '{'{OP_FLUSH, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{3'd6, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1}, 1'b1, ST_ERR, 8'h00, 13'd0},
    '{'{3'd7, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, ST_ERR, 8'h00, 13'd0},
    '{'{OP_CREATE, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b1}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{OP_WRITE, 16'hFFFF, 16'h0000, 1'b0, 8'hAA, 1'b0}, 1'b1, ST_WRONG, 8'h00, 13'd0},
    '{'{OP_READ, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 1'b1}, 1'b1, ST_WRONG, 8'h00, 13'd0},
    '{'{OP_READ, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{OP_WRITE, 16'hFFFF, 16'h0000, 1'b1, 8'hFF, 1'b1}, 1'b1, ST_OK, 8'h00, 13'd1},
    '{'{OP_WRITE, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 1'b0}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_FORK, 16'h0000, 16'hFFFF, 1'b0, 8'h00, 1'b0}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_FORK, 16'h0001, 16'h1234, 1'b0, 8'h00, 1'b1}, 1'b1, ST_ERR, 8'h00, 13'd0},
    '{'{OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_READ, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b1}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_FLUSH, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_CLOSE, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{OP_READ, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b1}, 1'b1, ST_CLOSED, 8'h00, 13'd0},
    '{'{OP_CLOSE, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{OP_WRITE, 16'hFFFF, 16'h0000, 1'b1, 8'h55, 1'b1}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_CLOSE, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 1'b0}, 1'b1, ST_OK, 8'h00, 13'd0},
    '{'{OP_CLOSE, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1}, 1'b0, ST_OK, 8'h00, 13'd0},
    '{'{OP_CLOSE, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}, 1'b0, ST_OK, 8'h00, 13'd0}
  };

  // run limit
  initial begin
    #40ms;
    $display("multi_reader_ring_buffer regression: fail");
    $finish;
  end

  initial begin
    req_t r;
    res_t ex;
    wipe_state();
    for (int i = 0; i < 8; i++) pid_pool[i] = 16'($urandom);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < NDir; i++) begin
      ex = '{st: dir_tab[i].st, dout: dir_tab[i].dout, amt: dir_tab[i].amt,
             last: dir_tab[i].rq.last};
      send_beat(dir_tab[i].rq, dir_tab[i].typed, ex);
    end
    send_req(mk(OP_CLOSE, 16'h0000, 16'h0000, 1'b0, 8'h00));
    drain();

    // write a run of bytes, then read, reclaim and write more
    send_req(mk(OP_CREATE, pid_pool[0], 16'h0000, 1'b0, 8'h00));
    for (int i = 0; i < 200; i++)
      send_req(mk(OP_WRITE, pid_pool[0], 16'h0000, 1'b1, 8'($urandom)));
    send_req(mk(OP_FORK, pid_pool[1], pid_pool[0], 1'b0, 8'h00));
    for (int i = 0; i < 40; i++)
      send_req(mk(OP_READ, pid_pool[i % 2], 16'h0000, 1'b0, 8'h00));
    send_req(mk(OP_FLUSH, 16'h0000, 16'h0000, 1'b0, 8'h00));
    for (int i = 0; i < 30; i++)
      send_req(mk(OP_WRITE, pid_pool[1], 16'h0000, 1'b1, 8'($urandom)));
    send_req(mk(OP_CLOSE, pid_pool[1], 16'h0000, 1'b0, 8'h00));
    for (int i = 0; i < 20; i++)
      send_req(mk(OP_READ, pid_pool[0], 16'h0000, 1'b0, 8'h00));
    send_req(mk(OP_FLUSH, 16'h0000, 16'h0000, 1'b0, 8'h00));
    drain();

    // fill every slot, overflow the fork, then free and reuse one slot
    send_req(mk(OP_CREATE, pid_pool[2], 16'h0000, 1'b0, 8'h00));
    for (int i = 0; i < Procs + 1; i++)
      send_req(mk(OP_FORK, 16'(16'h0100 + i), pid_pool[2], 1'b0, 8'h00));
    send_req(mk(OP_CLOSE, 16'h0105, 16'h0000, 1'b0, 8'h00));
    send_req(mk(OP_CLOSE, 16'h0105, 16'h0000, 1'b1, 8'h00));
    send_req(mk(OP_FORK, 16'hBEEF, pid_pool[2], 1'b0, 8'h00));
    drain();

    // random traffic in three idle profiles, with one long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 19 : (ph == 1) ? 85 : 0;
      rx_idle = (ph == 0) ? 85 : (ph == 1) ? 19 : 0;
      send_req(mk(OP_CREATE, pid_pool[0], 16'h0000, 1'b0, 8'h00));
      for (int i = 0; i < 430; i++) begin
        if (ph == 2 && i == 100) hold_go = 1'b1;
        r = rand_req();
        if (r.op == OP_CREATE) begin
          for (int k = 1; k < 8; k++) pid_pool[k] = 16'($urandom);
          r.pid = pid_pool[0];
        end
        send_req(r);
      end
      drain();
    end

    $display("requests %0d, results %0d, error results %0d, dropped writes %0d",
             n_req, n_res, n_err, n_full);
    $display("covered error codes, fork and close paths, slot overflow, reclaim, stalls");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("multi_reader_ring_buffer regression: pass");
    end else begin
      $display("multi_reader_ring_buffer regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
